@@ src/lsc_pkg.sv @@
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int CW = 12;   // coordinate width
    localparam int FW = 16;   // fraction bits of t

    // Configuration register indexes
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    localparam logic signed [CW-1:0] RST_MIN = 12'sd100;
    localparam logic signed [CW-1:0] RST_MAX = 12'sd250;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } seg_t;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clipped_start_x;
        logic signed [CW-1:0] clipped_start_y;
        logic signed [CW-1:0] clipped_end_x;
        logic signed [CW-1:0] clipped_end_y;
    } clip_t;

    // Per-edge classification after the divider
    typedef struct packed {
        logic rej;     // edge alone rejects the segment
        logic is_in;   // quotient raises entry
        logic is_out;  // quotient lowers exit
    } edge_cls_t;

endpackage

@@ src/line_segment_clipper.sv @@
`timescale 1ns / 1ps

// Liang-Barsky segment clipper. One segment per clock may be started;
// the result strobes done after the p/q stage, the FW-stage divider
// pipeline, the entry/exit compare stage and the two-stage interpolator.
// There is no stall input: every result is shown for one cycle only and
// must be taken then. Window registers are written through
// cfg_we/cfg_addr/cfg_data and take effect at once.
module line_segment_clipper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lsc_pkg::seg_t              seg,
    output logic                       done,
    output lsc_pkg::clip_t             result,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [lsc_pkg::CW-1:0]     cfg_data
);
    localparam int CW = lsc_pkg::CW;
    localparam int FW = lsc_pkg::FW;
    localparam int NW = CW + 1;           // magnitude width
    localparam int SW = 4*CW + 3;         // side data per edge

    logic signed [CW-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmin_reg <= lsc_pkg::RST_MIN;
            xmax_reg <= lsc_pkg::RST_MAX;
            ymin_reg <= lsc_pkg::RST_MIN;
            ymax_reg <= lsc_pkg::RST_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lsc_pkg::REG_X_MIN: xmin_reg <= cfg_data;
                lsc_pkg::REG_X_MAX: xmax_reg <= cfg_data;
                lsc_pkg::REG_Y_MIN: ymin_reg <= cfg_data;
                lsc_pkg::REG_Y_MAX: ymax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: p, q per edge
    logic                 v1_reg;
    lsc_pkg::seg_t        s1_reg;
    logic signed [CW:0]   p_reg [4];
    logic signed [CW:0]   q_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= seg;
        p_reg[0] <= (CW+1)'(seg.start_x) - (CW+1)'(seg.end_x);
        p_reg[1] <= (CW+1)'(seg.end_x) - (CW+1)'(seg.start_x);
        p_reg[2] <= (CW+1)'(seg.start_y) - (CW+1)'(seg.end_y);
        p_reg[3] <= (CW+1)'(seg.end_y) - (CW+1)'(seg.start_y);
        q_reg[0] <= (CW+1)'(seg.start_x) - (CW+1)'(xmin_reg);
        q_reg[1] <= (CW+1)'(xmax_reg) - (CW+1)'(seg.start_x);
        q_reg[2] <= (CW+1)'(seg.start_y) - (CW+1)'(ymin_reg);
        q_reg[3] <= (CW+1)'(ymax_reg) - (CW+1)'(seg.start_y);
    end

    // Stage 2: classify edges, feed dividers
    logic [FW-1:0]        quo [4];
    lsc_pkg::edge_cls_t   cls_o [4];
    lsc_pkg::seg_t        seg_o;
    logic                 v_o [4];
    logic [FW:0]          g_tq [4];

    for (genvar e = 0; e < 4; e++) begin : g_edge
        logic [NW-1:0]       ap, aq;
        lsc_pkg::edge_cls_t  c;
        logic                one;
        logic [SW-1:0]       sd_out;
        logic [FW-1:0]       q_raw;
        logic                one_o;
        logic [FW:0]         tq;
        always_comb
        begin
            ap  = p_reg[e][CW] ? NW'(-p_reg[e]) : NW'(p_reg[e]);
            aq  = q_reg[e][CW] ? NW'(-q_reg[e]) : NW'(q_reg[e]);
            one = aq >= ap;
            c   = '0;
            if (p_reg[e] == 0)
                c.rej = q_reg[e][CW];
            else if (p_reg[e][CW])
            begin
                if (q_reg[e][CW])
                begin
                    if (aq > ap) c.rej = 1'b1;
                    else if (!one) c.is_in = 1'b1;
                    else c.is_in = 1'b1;
                end
            end
            else
            begin
                if (q_reg[e][CW]) c.rej = 1'b1;
                else if (!one) c.is_out = 1'b1;
            end
        end
        // equal magnitudes give t = 1: flagged by forcing den > num path
        lsc_div #(.NW(NW), .SW(SW + 1)) u_div (
            .clk(clk), .rst_n(rst_n), .vin(v1_reg),
            .num(one ? '0 : aq), .den(ap == 0 ? NW'(1) : ap),
            .side_in({one, c, s1_reg}),
            .vout(v_o[e]), .quo(q_raw),
            .side_out({one_o, sd_out})
        );
        assign quo[e]   = q_raw;
        assign cls_o[e] = sd_out[SW-1 -: 3];
        if (e == 0) begin : g_seg
            assign seg_o = sd_out[4*CW-1:0];
        end
        assign tq = one_o ? (FW+1)'(1) << FW : {1'b0, q_raw};
        assign g_tq[e] = tq;
    end

    // Stage 3: combine entry and exit
    logic                 v3_reg, vis3_reg;
    logic [FW:0]          tin_reg, tout_reg;
    lsc_pkg::seg_t        s3_reg;
    logic [FW:0]          tin, tout;
    logic                 rej;

    always_comb
    begin
        tin  = '0;
        tout = (FW+1)'(1) << FW;
        rej  = 1'b0;
        for (int e = 0; e < 4; e++)
        begin
            rej = rej | cls_o[e].rej;
            if (cls_o[e].is_in && g_tq[e] > tin) tin = g_tq[e];
            if (cls_o[e].is_out && g_tq[e] < tout) tout = g_tq[e];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v_o[0];
    end

    always_ff @(posedge clk)
    begin
        vis3_reg <= !rej && (tin <= tout);
        tin_reg  <= tin;
        tout_reg <= tout;
        s3_reg   <= seg_o;
    end

    // Stages 4-5: interpolation
    logic signed [CW+1:0] dx, dy;
    logic signed [CW-1:0] csx, csy, cex, cey;
    assign dx = (CW+2)'(s3_reg.end_x) - (CW+2)'(s3_reg.start_x);
    assign dy = (CW+2)'(s3_reg.end_y) - (CW+2)'(s3_reg.start_y);

    lsc_interp u_sx (.clk(clk), .base((CW+1)'(s3_reg.start_x)), .delta(dx),
                     .t(tin_reg), .res(csx));
    lsc_interp u_sy (.clk(clk), .base((CW+1)'(s3_reg.start_y)), .delta(dy),
                     .t(tin_reg), .res(csy));
    lsc_interp u_ex (.clk(clk), .base((CW+1)'(s3_reg.start_x)), .delta(dx),
                     .t(tout_reg), .res(cex));
    lsc_interp u_ey (.clk(clk), .base((CW+1)'(s3_reg.start_y)), .delta(dy),
                     .t(tout_reg), .res(cey));

    logic [1:0] v45_reg, vis45_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v45_reg <= '0;
        else
            v45_reg <= {v45_reg[0], v3_reg};
    end
    always_ff @(posedge clk)
        vis45_reg <= {vis45_reg[0], vis3_reg};

    // Output: zero coordinates on rejection
    assign done                   = v45_reg[1];
    assign result.visible         = vis45_reg[1];
    assign result.clipped_start_x = vis45_reg[1] ? csx : '0;
    assign result.clipped_start_y = vis45_reg[1] ? csy : '0;
    assign result.clipped_end_x   = vis45_reg[1] ? cex : '0;
    assign result.clipped_end_y   = vis45_reg[1] ? cey : '0;
endmodule

@@ src/lsc_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring fractional divider: floor(n/d * 2^FW), n < d.
// One quotient bit per stage, FW stages; side data rides along.
module lsc_div #(
    parameter int NW = 14,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vin,
    input  logic [NW-1:0] num,
    input  logic [NW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          vout,
    output logic [lsc_pkg::FW-1:0] quo,
    output logic [SW-1:0] side_out
);
    localparam int N = lsc_pkg::FW;

    logic [N:1]      v_reg;
    logic [NW:0]     r_reg [1:N];
    logic [NW-1:0]   d_reg [1:N];
    logic [N-1:0]    q_reg [1:N];
    logic [SW-1:0]   s_reg [1:N];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[N-1:1], vin};
    end

    // One subtract-and-compare per stage
    for (genvar i = 0; i < N; i++) begin : g_st
        logic [NW:0]   r_cur;
        logic [NW-1:0] d_cur;
        logic [N-1:0]  q_cur;
        logic [SW-1:0] s_cur;
        logic [NW+1:0] sh;
        logic          ge;
        if (i == 0) begin : g_first
            assign r_cur = {1'b0, num};
            assign d_cur = den;
            assign q_cur = '0;
            assign s_cur = side_in;
        end
        else begin : g_rest
            assign r_cur = r_reg[i];
            assign d_cur = d_reg[i];
            assign q_cur = q_reg[i];
            assign s_cur = s_reg[i];
        end
        always_comb
        begin
            sh = {r_cur, 1'b0};
            ge = sh >= {2'b0, d_cur};
        end
        always_ff @(posedge clk)
        begin
            r_reg[i+1] <= ge ? (NW+1)'(sh - {2'b0, d_cur}) : sh[NW:0];
            d_reg[i+1] <= d_cur;
            q_reg[i+1] <= {q_cur[N-2:0], ge};
            s_reg[i+1] <= s_cur;
        end
    end

    assign vout     = v_reg[N];
    assign quo      = q_reg[N];
    assign side_out = s_reg[N];
endmodule

@@ src/lsc_interp.sv @@
`timescale 1ns / 1ps

// base + t*delta / 2^FW truncated toward zero; two register stages.
module lsc_interp (
    input  logic clk,
    input  logic signed [lsc_pkg::CW:0] base,
    input  logic signed [lsc_pkg::CW+1:0] delta,
    input  logic [lsc_pkg::FW:0] t,
    output logic signed [lsc_pkg::CW-1:0] res
);
    localparam int CW = lsc_pkg::CW;
    localparam int FW = lsc_pkg::FW;
    localparam int PW = CW + FW + 3;

    logic signed [PW-1:0] prod_reg;
    logic signed [CW:0]   base_reg;
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] tr;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(delta) * $signed({1'b0, t});
        base_reg <= base;
    end

    // Exact sum then truncate toward zero
    always_comb
    begin
        sum = (PW'(base_reg) <<< FW) + prod_reg;
        if (sum < 0)
            tr = (sum + PW'((1 << FW) - 1)) >>> FW;
        else
            tr = sum >>> FW;
    end

    always_ff @(posedge clk)
        res <= tr[CW-1:0];
endmodule

@@ src/lsc_checker.sv @@
`timescale 1ns / 1ps

module lsc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input lsc_pkg::clip_t result
);
    localparam int LAT = lsc_pkg::FW + 4;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after fixed latency");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.visible) |-> (result.clipped_start_x == 0 &&
            result.clipped_end_x == 0 && result.clipped_start_y == 0 &&
            result.clipped_end_y == 0))
        else $error("rejected segment with nonzero coordinates");

    a_nobusy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);

@@ verif/tb_line_segment_clipper.sv @@
`timescale 1ns / 1ps

module tb_line_segment_clipper;

    localparam int CW          = lsc_pkg::CW;
    localparam int FW          = lsc_pkg::FW;
    localparam int LATENCY     = FW + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint T_ONE   = 64'sd1 << FW;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lsc_pkg::seg_t       seg;
    logic                done;
    lsc_pkg::clip_t      result;
    logic                cfg_we;
    logic [1:0]          cfg_addr;
    logic [CW-1:0]       cfg_data;

    line_segment_clipper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .seg      (seg),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Window copy used for prediction
    logic signed [CW-1:0] win_x_lo, win_x_hi, win_y_lo, win_y_hi;

    lsc_pkg::seg_t   seg_queue[$];
    lsc_pkg::clip_t  clip_queue[$];
    int     mismatches;
    int     cycles;
    bit     driver_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Quotient |n|/|d| with FW fraction bits, saturated at one
    function automatic longint quot(longint n, longint d);
        if (n >= d)
            return T_ONE;
        return (n << FW) / d;
    endfunction

    // base + t*delta, truncated toward zero
    function automatic longint lerp(longint base, longint delta, longint t);
        longint num;
        longint q;
        num = (base << FW) + t * delta;
        q = num / T_ONE;  // SV division truncates toward zero
        return q;
    endfunction

    function automatic lsc_pkg::clip_t clip_segment(lsc_pkg::seg_t s);
        longint x1, y1, dx, dy, ap, aq, tq, t_in, t_out;
        longint p[4], q[4];
        bit reject;
        lsc_pkg::clip_t r;
        x1 = s.start_x;
        y1 = s.start_y;
        dx = longint'(s.end_x) - x1;
        dy = longint'(s.end_y) - y1;
        p[0] = -dx; q[0] = x1 - win_x_lo;
        p[1] = dx;  q[1] = longint'(win_x_hi) - x1;
        p[2] = -dy; q[2] = y1 - win_y_lo;
        p[3] = dy;  q[3] = longint'(win_y_hi) - y1;
        t_in = 0;
        t_out = T_ONE;
        reject = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            ap = p[i] < 0 ? -p[i] : p[i];
            aq = q[i] < 0 ? -q[i] : q[i];
            if (p[i] == 0)
            begin
                if (q[i] < 0) reject = 1'b1;
            end
            else if (p[i] < 0)
            begin
                if (q[i] < 0)
                begin
                    if (aq > ap) reject = 1'b1;
                    else
                    begin
                        tq = quot(aq, ap);
                        if (tq > t_in) t_in = tq;
                    end
                end
            end
            else if (q[i] < 0)
                reject = 1'b1;
            else if (aq < ap)
            begin
                tq = quot(aq, ap);
                if (tq < t_out) t_out = tq;
            end
        end
        if (t_in > t_out) reject = 1'b1;
        r = '0;
        if (!reject)
        begin
            r.visible         = 1'b1;
            r.clipped_start_x = CW'(lerp(x1, dx, t_in));
            r.clipped_start_y = CW'(lerp(y1, dy, t_in));
            r.clipped_end_x   = CW'(lerp(x1, dx, t_out));
            r.clipped_end_y   = CW'(lerp(y1, dy, t_out));
        end
        return r;
    endfunction

    // Register write at the falling edge, predictor copy updated alongside
    task automatic write_window(logic [1:0] idx, logic signed [CW-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            lsc_pkg::REG_X_MIN: win_x_lo = val;
            lsc_pkg::REG_X_MAX: win_x_hi = val;
            lsc_pkg::REG_Y_MIN: win_y_lo = val;
            lsc_pkg::REG_Y_MAX: win_y_hi = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_window(int xl, int xh, int yl, int yh);
        write_window(lsc_pkg::REG_X_MIN, CW'(xl));
        write_window(lsc_pkg::REG_X_MAX, CW'(xh));
        write_window(lsc_pkg::REG_Y_MIN, CW'(yl));
        write_window(lsc_pkg::REG_Y_MAX, CW'(yh));
    endtask

    // Wait for the pipeline to drain before touching the window
    task automatic drain();
        wait (seg_queue.size() == 0 && driver_idle && clip_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return {1'b1, {(CW-1){1'b0}}};
        if (k == 1) return {1'b0, {(CW-1){1'b1}}};
        if (k < 5) return CW'($urandom);
        return CW'($signed($urandom_range(0, 400)) - 50);
    endfunction

    function automatic lsc_pkg::seg_t mk_seg(int ax, int ay, int bx, int by);
        lsc_pkg::seg_t s;
        s.start_x = CW'(ax);
        s.start_y = CW'(ay);
        s.end_x   = CW'(bx);
        s.end_y   = CW'(by);
        return s;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            seg_queue.push_back({rand_coord(), rand_coord(), rand_coord(), rand_coord()});
        drain();
    endtask

    // Driver: one transfer per item, random gap after each
    int gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            seg         <= '0;
            gap         <= 0;
            driver_idle <= 1'b1;
        end
        else if (start && busy)
        begin
            // hold until accepted
        end
        else if (gap > 0)
        begin
            start <= 1'b0;
            gap   <= gap - 1;
        end
        else if (seg_queue.size() > 0)
        begin
            start       <= 1'b1;
            seg         <= seg_queue.pop_front();
            driver_idle <= 1'b0;
            gap         <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end
        else
        begin
            start       <= 1'b0;
            driver_idle <= 1'b1;
        end
    end

    // Monitor: predict on accepted transfers, check on strobes
    always @(posedge clk)
    begin
        lsc_pkg::clip_t exp_r;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (start && !busy)
                clip_queue.push_back(clip_segment(seg));
            if (done)
            begin
                if (clip_queue.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    exp_r = clip_queue.pop_front();
                    if (result !== exp_r)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h got %h", exp_r, result);
                    end
                end
            end
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb_line_segment_clipper: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        mismatches = 0;
        cycles     = 0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        win_x_lo   = lsc_pkg::RST_MIN;
        win_x_hi   = lsc_pkg::RST_MAX;
        win_y_lo   = lsc_pkg::RST_MIN;
        win_y_hi   = lsc_pkg::RST_MAX;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset window, inside, crossing, outside, degenerate, extremes
        seg_queue.push_back(mk_seg(150, 150, 200, 200));
        seg_queue.push_back(mk_seg(0, 0, 400, 400));
        seg_queue.push_back(mk_seg(0, 175, 400, 175));
        seg_queue.push_back(mk_seg(175, 0, 175, 400));
        seg_queue.push_back(mk_seg(0, 0, 50, 50));
        seg_queue.push_back(mk_seg(300, 300, 400, 400));
        seg_queue.push_back(mk_seg(120, 120, 120, 120));
        seg_queue.push_back(mk_seg(50, 50, 50, 50));
        seg_queue.push_back(mk_seg(0, 300, 300, 0));
        seg_queue.push_back(mk_seg(0, 290, 290, 0));
        seg_queue.push_back(mk_seg(100, 100, 250, 250));
        seg_queue.push_back(mk_seg(250, 100, 100, 250));
        seg_queue.push_back(mk_seg(-2048, -2048, 2047, 2047));
        seg_queue.push_back(mk_seg(2047, -2048, -2048, 2047));
        seg_queue.push_back(mk_seg(-2048, 175, 2047, 176));
        seg_queue.push_back(mk_seg(99, 175, 101, 177));
        seg_queue.push_back(mk_seg(251, 175, 249, 173));
        seg_queue.push_back(mk_seg(-1, -1, 7, 3));
        drain();

        random_phase(500);

        // Full-range window
        set_window(-2048, 2047, -2048, 2047);
        seg_queue.push_back(mk_seg(-2048, -2048, 2047, 2047));
        seg_queue.push_back(mk_seg(2047, 2047, -2048, -2048));
        random_phase(400);

        // Single-point window
        set_window(0, 0, 0, 0);
        seg_queue.push_back(mk_seg(-5, -5, 5, 5));
        seg_queue.push_back(mk_seg(-3, 0, 7, 0));
        random_phase(200);

        // Inverted window
        set_window(300, 50, 300, 50);
        random_phase(150);

        // Window mostly in the negative quadrant, odd extents
        set_window(-1500, -7, -2048, 13);
        random_phase(350);

        // Random windows
        for (int k = 0; k < 4; k++)
        begin
            set_window($signed($urandom_range(0, 600)) - 300, $urandom_range(0, 600),
                       $signed($urandom_range(0, 600)) - 300, $urandom_range(0, 600));
            random_phase(85);
        end

        drain();
        if (mismatches == 0)
            $display("tb_line_segment_clipper: done, clean");
        else
            $display("tb_line_segment_clipper: done, errors");
        $finish;
    end

endmodule
